// ----- src/pstd_pkg.sv -----
// ----------------------------------------------------------------------------
// pstd_pkg
// Shared types, register map and alphabet lookup for the packed symbol
// text decoder.
// ----------------------------------------------------------------------------
package pstd_pkg;

	// register byte addresses (index = paddr[2])
	localparam logic REG_SYMBOL_BITS = 1'b0;
	localparam logic REG_CHAR_OFFSET = 1'b1;

	localparam logic [4:0]  SYMBOL_BITS_RST = 5'd8;
	localparam logic [15:0] CHAR_OFFSET_RST = 16'd0;
	localparam logic [15:0] ALPHABET_SIZE   = 16'd31;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [15:0] char_code;
		logic        run_last;
		logic        string_end;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // append the accepted byte
		logic emit;     // take one symbol into the output register
		logic cap;      // this symbol is the eighth of the item
		logic clear;    // drop leftover bits at end of string
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic sym_avail;
		logic out_run_last;
		logic last_item;
	} dp_sts_t;

	// symbols 1..31 map to the fixed alphabet, symbol 0 to null
	function automatic logic [15:0] alpha_char(input logic [4:0] sym);
		logic [15:0] c;
		unique case (sym)
			5'd1:  c = 16'h0030; // 0
			5'd2:  c = 16'h0031; // 1
			5'd3:  c = 16'h0032; // 2
			5'd4:  c = 16'h0033; // 3
			5'd5:  c = 16'h0034; // 4
			5'd6:  c = 16'h0035; // 5
			5'd7:  c = 16'h0036; // 6
			5'd8:  c = 16'h0073; // s
			5'd9:  c = 16'h0074; // t
			5'd10: c = 16'h0072; // r
			5'd11: c = 16'h006E; // n
			5'd12: c = 16'h0075; // u
			5'd13: c = 16'h006D; // m
			5'd14: c = 16'h0028; // (
			5'd15: c = 16'h0029; // )
			5'd16: c = 16'h005B; // [
			5'd17: c = 16'h005D; // ]
			5'd18: c = 16'h003C; // <
			5'd19: c = 16'h003E; // >
			5'd20: c = 16'h0025; // %
			5'd21: c = 16'h0023; // #
			5'd22: c = 16'h002F; // /
			5'd23: c = 16'h003A; // :
			5'd24: c = 16'h002D; // -
			5'd25: c = 16'h0027; // apostrophe
			5'd26: c = 16'h0022; // double quote
			5'd27: c = 16'h0020; // space
			5'd28: c = 16'h002C; // ,
			5'd29: c = 16'h002E; // .
			5'd30: c = 16'h0021; // !
			5'd31: c = 16'h000A; // newline
			default: c = 16'h0000;
		endcase
		return c;
	endfunction

endpackage

// ----- src/pstd_ctrl.sv -----
// ----------------------------------------------------------------------------
// pstd_ctrl
// Sequencer: accepts one byte, then pulls symbols out one at a time into
// the output register until the accumulator runs short or the eighth symbol is out.
// ----------------------------------------------------------------------------
module pstd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output pstd_pkg::dp_cmd_t  cmd,
	input  pstd_pkg::dp_sts_t  sts
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_OUT
	} state_t;

	state_t     state_q;
	logic [2:0] n_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_SCAN: begin
				cmd.emit  = sts.sym_avail;
				cmd.cap   = (n_q == 3'd7);
				cmd.clear = !sts.sym_avail && sts.last_item;
			end
			S_OUT: begin
				if (!out_stall) begin
					cmd.emit  = !sts.out_run_last;
					cmd.cap   = (n_q == 3'd7);
					cmd.clear = sts.out_run_last && sts.last_item;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SCAN;
						n_q     <= '0;
					end
				end
				S_SCAN: begin
					if (sts.sym_avail) begin
						state_q <= S_OUT;
						n_q     <= n_q + 3'd1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						if (sts.out_run_last) begin
							state_q <= S_IDLE;
						end else begin
							n_q <= n_q + 3'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- src/pstd_dp.sv -----
// ----------------------------------------------------------------------------
// pstd_dp
// Bit accumulator, symbol extraction, character mapping and output
// register.
// ----------------------------------------------------------------------------
module pstd_dp #(
	parameter int MAX_SYMBOL_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pstd_pkg::dp_cmd_t   cmd,
	output pstd_pkg::dp_sts_t   sts,
	input  pstd_pkg::in_item_t  in_item,
	input  logic [4:0]          symbol_bits,
	input  logic [15:0]         char_offset,
	output pstd_pkg::out_item_t out_item
);

	localparam int SW = MAX_SYMBOL_BITS + 7;          // store width
	localparam int CW = $clog2(MAX_SYMBOL_BITS + 8);  // count width

	logic [SW-1:0]              store_q;
	logic [CW-1:0]              count_q;
	logic                       last_q;
	pstd_pkg::out_item_t        out_q;

	logic [CW-1:0]              w_eff;
	logic [CW-1:0]              cnt_clamp;
	logic [CW-1:0]              nxt_count;
	logic [MAX_SYMBOL_BITS-1:0] sym_mask;
	logic [MAX_SYMBOL_BITS-1:0] sym;
	logic [15:0]                sym16;
	logic [15:0]                char_val;
	logic                       run_last;

	// clamp the configured width to 1..MAX_SYMBOL_BITS
	always_comb begin
		if (symbol_bits == 5'd0) begin
			w_eff = CW'(1);
		end else if (symbol_bits > 5'(MAX_SYMBOL_BITS)) begin
			w_eff = CW'(MAX_SYMBOL_BITS);
		end else begin
			w_eff = CW'(symbol_bits);
		end
	end

	assign cnt_clamp = (count_q > CW'(MAX_SYMBOL_BITS - 1)) ?
		CW'(MAX_SYMBOL_BITS - 1) : count_q;
	assign nxt_count = count_q - w_eff;
	assign sym_mask  = ~({MAX_SYMBOL_BITS{1'b1}} << w_eff);
	assign sym       = store_q[MAX_SYMBOL_BITS-1:0] & sym_mask;
	assign sym16     = 16'(sym);
	assign char_val  = (sym16 <= pstd_pkg::ALPHABET_SIZE) ?
		pstd_pkg::alpha_char(sym16[4:0]) :
		16'(sym16 + char_offset - pstd_pkg::ALPHABET_SIZE);
	assign run_last  = (nxt_count < w_eff) || cmd.cap;

	assign sts.sym_avail    = (count_q >= w_eff);
	assign sts.out_run_last = out_q.run_last;
	assign sts.last_item    = last_q;
	assign out_item         = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
			count_q <= '0;
			last_q  <= 1'b0;
		end else if (cmd.load) begin
			store_q <= store_q | (SW'(in_item.data_byte) << cnt_clamp);
			count_q <= cnt_clamp + CW'(8);
			last_q  <= in_item.last_byte;
		end else if (cmd.emit) begin
			store_q <= store_q >> w_eff;
			count_q <= nxt_count;
		end else if (cmd.clear) begin
			store_q <= '0;
			count_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.char_code  <= char_val;
			out_q.run_last   <= run_last;
			out_q.string_end <= run_last && last_q;
		end
	end

endmodule

// ----- src/packed_symbol_text_decoder_top.sv -----
// ----------------------------------------------------------------------------
// packed_symbol_text_decoder_top
// Unpacks bytes of a string into fixed-width symbols and maps each symbol
// to a 16-bit character.
// ----------------------------------------------------------------------------
// timing: the first character of an item is on offer once the sequencer's scan
//   step after the byte's acceptance is done; further characters follow one per
//   cycle while out_stall is low. A new byte is taken only after every character
//   of the previous one is taken and the sequencer, through its scan step, has
//   returned to idle
// reset: arst_n clears the bit accumulator and sequencer, symbol_bits = 8,
//   char_offset = 0
// ----------------------------------------------------------------------------
module packed_symbol_text_decoder_top #(
	parameter int MAX_SYMBOL_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// byte input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  pstd_pkg::in_item_t  in_data,
	// character output channel
	output logic                out_valid,
	input  logic                out_stall,
	output pstd_pkg::out_item_t out_data,
	// register port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [4:0]        symbol_bits_q;
	logic [15:0]       char_offset_q;
	logic              reg_wr;
	logic              reg_idx;
	pstd_pkg::dp_cmd_t cmd;
	pstd_pkg::dp_sts_t sts;

	// register file: symbol width at 0x0, character offset at 0x4
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_bits_q <= pstd_pkg::SYMBOL_BITS_RST;
			char_offset_q <= pstd_pkg::CHAR_OFFSET_RST;
		end else if (reg_wr) begin
			unique case (reg_idx)
				pstd_pkg::REG_SYMBOL_BITS: symbol_bits_q <= pwdata[4:0];
				pstd_pkg::REG_CHAR_OFFSET: char_offset_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read back the raw register values
	always_comb begin
		unique case (reg_idx)
			pstd_pkg::REG_SYMBOL_BITS: prdata = 32'(symbol_bits_q);
			pstd_pkg::REG_CHAR_OFFSET: prdata = 32'(char_offset_q);
			default:                   prdata = '0;
		endcase
	end

	// sequencer: one byte in, then one symbol per cycle out while out_stall is low
	pstd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// accumulator, symbol mapping and output register
	pstd_dp #(
		.MAX_SYMBOL_BITS (MAX_SYMBOL_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_item     (in_data),
		.symbol_bits (symbol_bits_q),
		.char_offset (char_offset_q),
		.out_item    (out_data)
	);

	// no byte is taken while a character is on offer
	a_busy_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("byte input open while a character is pending");

	// end of string is only flagged on the last character of a byte
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.string_end) |-> out_data.run_last)
		else $error("string_end without run_last");

	// the last character of a byte closes the output burst
	a_burst_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_data.run_last) |=> !out_valid)
		else $error("character offered after the last one of a byte");

	// an accepted byte is scanned before any character appears
	a_scan_first: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (!out_valid && in_stall))
		else $error("no scan cycle after byte accept");

endmodule

// ----- sim/tb_packed_symbol_text_decoder_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packed_symbol_text_decoder_top
// Self-checking bench for the packed symbol text decoder. Strings of bytes go
// in on the byte channel, and a bit-level model of the symbol unpacker
// predicts every character. Both channels idle and stall at random, and the
// symbol width and character offset are rewritten between phases over the
// register port.
// ----------------------------------------------------------------------------
module tb_packed_symbol_text_decoder_top;

	// register byte addresses, index in bit 2
	localparam logic [2:0] ADDR_SYMBOL_BITS = {pstd_pkg::REG_SYMBOL_BITS, 2'b00};
	localparam logic [2:0] ADDR_CHAR_OFFSET = {pstd_pkg::REG_CHAR_OFFSET, 2'b00};

	// fixed alphabet for symbols 1..31, first symbol in the top byte
	localparam logic [8*31-1:0] GLYPHS = "0123456strnum()[]<>%#/:-'\" ,.!\n";

	// percent of cycles a side idles
	localparam int IDLE_PCT = 24;

	logic                clk     = 1'b0;
	logic                arst_n  = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	pstd_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	pstd_pkg::out_item_t out_data;
	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [2:0]          paddr   = '0;
	logic [31:0]         pwdata  = '0;
	logic [31:0]         prdata;
	logic                pready;

	// bytes waiting to be offered, characters waiting to come out
	pstd_pkg::in_item_t  byte_q [$];
	pstd_pkg::out_item_t char_q [$];

	// model state: register copies and the bit accumulator
	logic [4:0]  sym_bits  = pstd_pkg::SYMBOL_BITS_RST;
	logic [15:0] chr_off   = pstd_pkg::CHAR_OFFSET_RST;
	logic [22:0] acc_bits  = '0;
	int          acc_count = 0;

	int  errors      = 0;
	int  bytes_taken = 0;
	// calm: no idling on either side; long_hold: receiver holds off
	logic calm      = 1'b0;
	logic long_hold = 1'b0;

	packed_symbol_text_decoder_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// single reset at the start of the run
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// safety net against a hung handshake
	initial begin
		#5_000_000;
		$display("tb_packed_symbol_text_decoder_top failed");
		$finish;
	end

	task automatic report(input string what, input int got, input int want);
		errors++;
		$display("mismatch: %s got %0h expected %0h", what, got, want);
	endtask

	// symbol to character: null, alphabet, or offset code wrapped to 16 bits
	function automatic logic [15:0] glyph_of(input logic [15:0] sym);
		int idx;
		if (sym == 16'd0)
			return 16'd0;
		if (sym <= pstd_pkg::ALPHABET_SIZE) begin
			idx = 31 - int'(sym);
			return {8'h00, GLYPHS[8*idx +: 8]};
		end
		return sym + chr_off - pstd_pkg::ALPHABET_SIZE;
	endfunction

	// append one byte LSB-first and queue every character it releases
	task automatic predict_chars(input pstd_pkg::in_item_t item);
		int                  w;
		int                  n;
		logic [22:0]         mask;
		pstd_pkg::out_item_t batch [8];
		w = (sym_bits == 5'd0) ? 1 : ((sym_bits > 5'd16) ? 16 : int'(sym_bits));
		mask = (23'd1 << w) - 23'd1;
		n = 0;
		if (acc_count > 15)
			acc_count = 15;
		acc_bits = acc_bits | (23'(item.data_byte) << acc_count);
		acc_count += 8;
		while (acc_count >= w && n < 8) begin
			batch[n].char_code  = glyph_of(16'(acc_bits & mask));
			batch[n].run_last   = 1'b0;
			batch[n].string_end = 1'b0;
			acc_bits = acc_bits >> w;
			acc_count -= w;
			n++;
		end
		// last character of the byte carries the run and string marks
		if (n > 0) begin
			batch[n-1].run_last   = 1'b1;
			batch[n-1].string_end = item.last_byte;
		end
		for (int k = 0; k < n; k++)
			char_q.push_back(batch[k]);
		// end of string drops the leftover bits
		if (item.last_byte) begin
			acc_bits  = '0;
			acc_count = 0;
		end
	endtask

	// byte driver: a new item only once the previous one is taken
	always @(posedge clk) begin : byte_driver
		logic fire;
		if (arst_n) begin
			fire = in_valid && !in_stall;
			if (fire) begin
				predict_chars(in_data);
				bytes_taken++;
			end
			if (fire || !in_valid) begin
				if (byte_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					in_data  <= byte_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// character monitor: compare with the oldest prediction, then pick stall
	always @(posedge clk) begin : char_monitor
		pstd_pkg::out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (char_q.size() == 0) begin
					report("character with none pending", out_data.char_code, 0);
				end else begin
					want = char_q.pop_front();
					if (out_data.char_code !== want.char_code)
						report("char_code", out_data.char_code, want.char_code);
					if (out_data.run_last !== want.run_last)
						report("run_last", out_data.run_last, want.run_last);
					if (out_data.string_end !== want.string_end)
						report("string_end", out_data.string_end, want.string_end);
				end
			end
			out_stall <= long_hold || (!calm && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// receiver holds off for a long stretch while bytes keep coming
	initial begin
		wait (bytes_taken >= 120);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (400) @(posedge clk);
		long_hold <= 1'b0;
	end

	task automatic push_byte(input logic [7:0] b, input logic last);
		pstd_pkg::in_item_t item;
		item.data_byte = b;
		item.last_byte = last;
		byte_q.push_back(item);
	endtask

	// sender pauses until every character is out, then the pipe drains
	task automatic settle();
		while (byte_q.size() != 0 || in_valid || char_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// register write with a setup and an access phase, model copy updated at the write edge
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_SYMBOL_BITS)
			sym_bits = val[4:0];
		else
			chr_off = val[15:0];
	endtask

	task automatic write_cfg(input logic [4:0] sb, input logic [15:0] off);
		settle();
		reg_write(ADDR_SYMBOL_BITS, {27'd0, sb});
		reg_write(ADDR_CHAR_OFFSET, {16'd0, off});
	endtask

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// mostly whole strings, some lone bytes with a random end mark;
	// the phase may stop mid-string so bits carry over a width change
	task automatic random_phase(input logic [4:0] sb, input logic [15:0] off,
			input int count, input logic quiet);
		int pushed;
		int len;
		write_cfg(sb, off);
		calm <= quiet;
		pushed = 0;
		while (pushed < count) begin
			if ($urandom_range(0, 7) == 0) begin
				push_byte(pick_byte(), 1'($urandom_range(0, 1)));
				pushed++;
			end else begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len && pushed < count; i++) begin
					push_byte(pick_byte(), i == len - 1);
					pushed++;
				end
			end
		end
	endtask

	initial begin : main_seq
		wait (arst_n);
		@(posedge clk);

		// reset widths: null, top byte past the alphabet, alphabet edges
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'h1F, 1'b0);
		push_byte(8'h20, 1'b1);
		push_byte(8'h80, 1'b1);

		// one-bit symbols: eight characters per byte
		write_cfg(5'd1, 16'hFFFF);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(8'hA5, 1'b1);

		// widest symbols, offset wraps; lone last byte gives no character
		write_cfg(5'd16, 16'hFFFF);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h12, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b1);

		// width zero read as one, above the maximum read as the maximum
		write_cfg(5'd0, 16'h1234);
		push_byte(8'h5A, 1'b1);
		write_cfg(5'd17, 16'h0000);
		push_byte(8'h34, 1'b0);
		push_byte(8'h12, 1'b1);

		// width change with bits still pending
		write_cfg(5'd5, 16'h0040);
		push_byte(8'hC3, 1'b0);
		write_cfg(5'd3, 16'h0040);
		push_byte(8'h0F, 1'b0);
		push_byte(8'hF0, 1'b1);

		random_phase(5'd5, 16'($urandom_range(0, 65535)), 45, 1'b0);
		random_phase(5'd6, 16'h0000, 45, 1'b0);
		random_phase(5'd31, 16'hFFFF, 45, 1'b0);
		random_phase(5'd2, 16'($urandom_range(0, 65535)), 40, 1'b0);
		random_phase(5'd7, 16'($urandom_range(0, 65535)), 45, 1'b1);
		random_phase(5'd1, 16'($urandom_range(0, 65535)), 30, 1'b0);
		random_phase(5'd16, 16'h0000, 45, 1'b0);
		random_phase(5'd0, 16'($urandom_range(0, 65535)), 25, 1'b0);
		random_phase(5'd12, 16'($urandom_range(0, 65535)), 40, 1'b0);
		calm <= 1'b0;

		// drain with a bound, then give stray characters time to show
		for (int k = 0; k < 20000 && (byte_q.size() != 0 || in_valid || char_q.size() != 0);
				k++)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (char_q.size() != 0)
			report("characters never delivered", char_q.size(), 0);

		if (errors == 0)
			$display("tb_packed_symbol_text_decoder_top passed");
		else
			$display("tb_packed_symbol_text_decoder_top failed");
		$finish;
	end

endmodule
